// File: rtl/core/ryuv_pkg.sv
// ----------------------------------------------------------------------------
// ryuv_pkg
// Shared widths, conversion coefficients, register indexes and the queue
// entry passed from the pixel front end to the conversion back end.
// ----------------------------------------------------------------------------
package ryuv_pkg;

	localparam int COMP_W = 8;
	localparam int CFG_W  = 13;
	localparam int CNT_W  = 14;
	localparam int LIDX_W = 24;
	localparam int CIDX_W = 22;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int QUEUE_DEPTH = 4;

	localparam int Y_R   = 66;
	localparam int Y_G   = 129;
	localparam int Y_B   = 25;
	localparam int U_R   = -38;
	localparam int U_G   = -74;
	localparam int U_B   = 112;
	localparam int V_R   = 112;
	localparam int V_G   = -94;
	localparam int V_B   = -18;
	localparam int Y_OFF = 16;
	localparam int C_OFF = 128;

	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
		logic [CNT_W-1:0]  col;
		logic [CNT_W-1:0]  row;
		logic              chroma_valid;
		logic              end_of_frame;
	} work_t;

endpackage

// File: rtl/core/ryuv_pix_if.sv
// ----------------------------------------------------------------------------
// ryuv_pix_if
// RGB24 pixel channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ryuv_pix_if;

	logic                          valid;
	logic                          ready;
	logic [ryuv_pkg::COMP_W-1:0]   red;
	logic [ryuv_pkg::COMP_W-1:0]   green;
	logic [ryuv_pkg::COMP_W-1:0]   blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// File: rtl/core/ryuv_res_if.sv
// ----------------------------------------------------------------------------
// ryuv_res_if
// Converted YUV result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ryuv_res_if;

	logic                          valid;
	logic                          ready;
	logic [ryuv_pkg::COMP_W-1:0]   luma;
	logic [ryuv_pkg::LIDX_W-1:0]   luma_index;
	logic                          chroma_valid;
	logic [ryuv_pkg::COMP_W-1:0]   chroma_cb;
	logic [ryuv_pkg::COMP_W-1:0]   chroma_cr;
	logic [ryuv_pkg::CIDX_W-1:0]   chroma_index;
	logic                          end_of_frame;

	modport source (
		output valid, output luma, output luma_index, output chroma_valid,
		output chroma_cb, output chroma_cr, output chroma_index, output end_of_frame,
		input ready
	);
	modport sink (
		input valid, input luma, input luma_index, input chroma_valid,
		input chroma_cb, input chroma_cr, input chroma_index, input end_of_frame,
		output ready
	);

endinterface

// File: rtl/core/ryuv_front.sv
// ----------------------------------------------------------------------------
// ryuv_front
// Accepts pixels, tracks raster position and tags each transaction with its
// position, chroma sampling and end-of-frame before queueing it.
// ----------------------------------------------------------------------------
module ryuv_front #(
	parameter int COL_W = 12,
	parameter int ROW_W = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ryuv_pix_if.sink                     pixel,
	input  logic [ryuv_pkg::CFG_W-1:0]   width_eff,
	input  logic [ryuv_pkg::CFG_W-1:0]   height_eff,
	input  logic                         q_full,
	output logic                         q_push,
	output ryuv_pkg::work_t              q_data
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col;
	logic             last_row;

	assign pixel.ready = !q_full;
	assign q_push      = pixel.valid && !q_full;

	assign last_col = ryuv_pkg::CNT_W'(col_q) >=
		(ryuv_pkg::CNT_W'(width_eff) - ryuv_pkg::CNT_W'(1));
	assign last_row = ryuv_pkg::CNT_W'(row_q) >=
		(ryuv_pkg::CNT_W'(height_eff) - ryuv_pkg::CNT_W'(1));

	always_comb begin
		q_data.red          = pixel.red;
		q_data.green        = pixel.green;
		q_data.blue         = pixel.blue;
		q_data.col          = ryuv_pkg::CNT_W'(col_q);
		q_data.row          = ryuv_pkg::CNT_W'(row_q);
		q_data.chroma_valid = !col_q[0] && !row_q[0];
		q_data.end_of_frame = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/ryuv_queue.sv
// ----------------------------------------------------------------------------
// ryuv_queue
// Short FIFO between front end and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module ryuv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ryuv_pkg::work_t  push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output ryuv_pkg::work_t  head
);

	localparam int AW = (ryuv_pkg::QUEUE_DEPTH > 1) ? $clog2(ryuv_pkg::QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(ryuv_pkg::QUEUE_DEPTH + 1);

	ryuv_pkg::work_t mem_q [ryuv_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = count_q == NW'(ryuv_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(ryuv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(ryuv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/ryuv_back.sv
// ----------------------------------------------------------------------------
// ryuv_back
// Two-stage conversion pipeline: color products with their offsets and index
// products in the first stage, index sums and chroma masking into the output register in the second.
// ----------------------------------------------------------------------------
module ryuv_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ryuv_pkg::CFG_W-1:0]   width_eff,
	input  logic                         q_valid,
	input  ryuv_pkg::work_t              q_data,
	output logic                         q_pop,
	ryuv_res_if.source                   yuv
);

	localparam int LPROD_W = ryuv_pkg::CNT_W + ryuv_pkg::CFG_W;
	localparam int CPROD_W = ryuv_pkg::CNT_W + ryuv_pkg::CFG_W - 2;

	logic                          advance;
	int                            r_i;
	int                            g_i;
	int                            b_i;
	int                            y_sum;
	int                            u_sum;
	int                            v_sum;
	logic [LPROD_W-1:0]            lprod;
	logic [CPROD_W-1:0]            cprod;

	logic                          valid_s1;
	logic [ryuv_pkg::COMP_W-1:0]   luma_s1;
	logic [ryuv_pkg::COMP_W-1:0]   u_s1;
	logic [ryuv_pkg::COMP_W-1:0]   v_s1;
	logic [ryuv_pkg::LIDX_W-1:0]   lprod_s1;
	logic [ryuv_pkg::CIDX_W-1:0]   cprod_s1;
	logic [ryuv_pkg::CNT_W-1:0]    col_s1;
	logic                          cvalid_s1;
	logic                          eof_s1;

	logic                          valid_s2;
	logic [ryuv_pkg::COMP_W-1:0]   luma_s2;
	logic [ryuv_pkg::LIDX_W-1:0]   lidx_s2;
	logic                          cvalid_s2;
	logic [ryuv_pkg::COMP_W-1:0]   u_s2;
	logic [ryuv_pkg::COMP_W-1:0]   v_s2;
	logic [ryuv_pkg::CIDX_W-1:0]   cidx_s2;
	logic                          eof_s2;

	assign advance = !valid_s2 || yuv.ready;
	assign q_pop   = advance && q_valid;

	always_comb begin
		r_i   = int'(q_data.red);
		g_i   = int'(q_data.green);
		b_i   = int'(q_data.blue);
		y_sum = ryuv_pkg::Y_R * r_i + ryuv_pkg::Y_G * g_i + ryuv_pkg::Y_B * b_i;
		u_sum = (ryuv_pkg::C_OFF * 256) + ryuv_pkg::U_R * r_i + ryuv_pkg::U_G * g_i
			+ ryuv_pkg::U_B * b_i;
		v_sum = (ryuv_pkg::C_OFF * 256) + ryuv_pkg::V_R * r_i + ryuv_pkg::V_G * g_i
			+ ryuv_pkg::V_B * b_i;
		lprod = LPROD_W'(q_data.row) * LPROD_W'(width_eff);
		cprod = CPROD_W'(q_data.row >> 1) * CPROD_W'(width_eff >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			luma_s1   <= y_sum[15:8] + ryuv_pkg::COMP_W'(ryuv_pkg::Y_OFF);
			u_s1      <= u_sum[15:8];
			v_s1      <= v_sum[15:8];
			lprod_s1  <= lprod[ryuv_pkg::LIDX_W-1:0];
			cprod_s1  <= cprod[ryuv_pkg::CIDX_W-1:0];
			col_s1    <= q_data.col;
			cvalid_s1 <= q_data.chroma_valid;
			eof_s1    <= q_data.end_of_frame;

			luma_s2   <= luma_s1;
			lidx_s2   <= lprod_s1 + ryuv_pkg::LIDX_W'(col_s1);
			cvalid_s2 <= cvalid_s1;
			u_s2      <= cvalid_s1 ? u_s1 : '0;
			v_s2      <= cvalid_s1 ? v_s1 : '0;
			cidx_s2   <= cvalid_s1 ? cprod_s1 + ryuv_pkg::CIDX_W'(col_s1 >> 1) : '0;
			eof_s2    <= eof_s1;
		end
	end

	assign yuv.valid        = valid_s2;
	assign yuv.luma         = luma_s2;
	assign yuv.luma_index   = lidx_s2;
	assign yuv.chroma_valid = cvalid_s2;
	assign yuv.chroma_cb    = u_s2;
	assign yuv.chroma_cr    = v_s2;
	assign yuv.chroma_index = cidx_s2;
	assign yuv.end_of_frame = eof_s2;

endmodule

// File: rtl/core/rgb_to_yuv420_planar.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_planar
// Streaming RGB24 to planar YUV 4:2:0 converter, BT.601 studio range.
//
// pixel: one RGB24 pixel per transaction, raster order.
// yuv:   one result per pixel: luma with its plane index, and on even rows
//        and even columns chroma U/V with the chroma plane index; chroma
//        fields read zero elsewhere. end_of_frame marks the last pixel.
// APB:   frame_width at 0x0, frame_height at 0x4, 13 bits each; out of range
//        values saturate to 1..MAX_WIDTH and 1..MAX_HEIGHT. Write only while
//        the stream is idle.
// Throughput: one pixel per clock, sustained, when yuv is ready.
// Path:  an accepted pixel passes a queue slot, then the two pipeline
//        stages of the back end, before its result is presented.
// Stall: a four-entry queue lets the front end keep taking pixels while
//        yuv is stalled; pixel.ready drops once the queue is full.
// Reset: counters restart at row 0, column 0; registers return to 640x480;
//        pipeline and queue empty.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_planar #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ryuv_pkg::APB_AW-1:0]   paddr,
	input  logic [ryuv_pkg::APB_DW-1:0]   pwdata,
	output logic [ryuv_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	ryuv_pix_if.sink                      pixel,
	ryuv_res_if.source                    yuv
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [ryuv_pkg::CFG_W-1:0] frame_width_q;
	logic [ryuv_pkg::CFG_W-1:0] frame_height_q;
	logic [ryuv_pkg::CFG_W-1:0] width_eff;
	logic [ryuv_pkg::CFG_W-1:0] height_eff;
	ryuv_pkg::reg_idx_t         reg_sel;
	logic                       wr_en;

	logic                       q_push;
	logic                       q_pop;
	logic                       q_full;
	logic                       q_valid;
	ryuv_pkg::work_t            q_in;
	ryuv_pkg::work_t            q_head;

	assign pready  = 1'b1;
	assign reg_sel = ryuv_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= ryuv_pkg::CFG_W'(ryuv_pkg::FRAME_WIDTH_RST);
			frame_height_q <= ryuv_pkg::CFG_W'(ryuv_pkg::FRAME_HEIGHT_RST);
		end else if (wr_en) begin
			case (reg_sel)
				ryuv_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[ryuv_pkg::CFG_W-1:0];
				ryuv_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[ryuv_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ryuv_pkg::REG_FRAME_WIDTH:  prdata = ryuv_pkg::APB_DW'(frame_width_q);
			ryuv_pkg::REG_FRAME_HEIGHT: prdata = ryuv_pkg::APB_DW'(frame_height_q);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		if (frame_width_q == '0) begin
			width_eff = ryuv_pkg::CFG_W'(1);
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			width_eff = ryuv_pkg::CFG_W'(MAX_WIDTH);
		end else begin
			width_eff = frame_width_q;
		end
		if (frame_height_q == '0) begin
			height_eff = ryuv_pkg::CFG_W'(1);
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			height_eff = ryuv_pkg::CFG_W'(MAX_HEIGHT);
		end else begin
			height_eff = frame_height_q;
		end
	end

	ryuv_front #(
		.COL_W (COL_W),
		.ROW_W (ROW_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	ryuv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	ryuv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.width_eff (width_eff),
		.q_valid   (q_valid),
		.q_data    (q_head),
		.q_pop     (q_pop),
		.yuv       (yuv)
	);

	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		yuv.valid |-> (yuv.luma >= 8'd16) && (yuv.luma <= 8'd235))
		else $error("luma out of studio range");

	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(yuv.valid && !yuv.chroma_valid) |->
			(yuv.chroma_cb == '0) && (yuv.chroma_cr == '0) && (yuv.chroma_index == '0))
		else $error("chroma fields set on non-sampled pixel");

	a_chroma_even: assert property (@(posedge clk) disable iff (!arst_n)
		(yuv.valid && yuv.chroma_valid) |-> !yuv.luma_index[0])
		else $error("chroma sample at odd luma index");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !pixel.ready)
		else $error("pixel taken while queue full");

endmodule
